### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk_i, held off while rst_ni is low
`define NNT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// concurrent check on clk_i, live through reset as well
`define NNT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/nnt_pkg.sv
package nnt_pkg;

  // default store capacity
  localparam int unsigned MAX_CITIES_DEF = 32;

  // field widths
  localparam int unsigned COORD_W = 16;
  localparam int unsigned CITY_W  = 6;
  localparam int unsigned STEP_W  = 17;
  localparam int unsigned TOTAL_W = 23;

  // squared distance: two 32-bit squares and a carry
  localparam int unsigned SQ_W = 2 * COORD_W + 1;

  // saturation value of the running total
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

endpackage

### src/nnt_if.sv
// city request: one coordinate pair, last_city starts the tour
interface nnt_city_if
  import nnt_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic               last_city;

  modport source (output valid, output coord_x, output coord_y, output last_city,
                  input ready);
  modport sink   (input valid, input coord_x, input coord_y, input last_city,
                  output ready);
endinterface

// move request: one step of the tour
interface nnt_move_if
  import nnt_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CITY_W-1:0]  city_index;
  logic [STEP_W-1:0]  step_distance;
  logic [TOTAL_W-1:0] total_distance;
  logic               tour_end;
  logic               overflow;

  modport source (output valid, output city_index, output step_distance,
                  output total_distance, output tour_end, output overflow,
                  input ready);
  modport sink   (input valid, input city_index, input step_distance,
                  input total_distance, input tour_end, input overflow,
                  output ready);
endinterface

### src/nearest_neighbour_tour.sv
// channel   dir  payload                                              accepted when
// city_i    in   coord_x, coord_y, last_city                          valid && ready
// move_o    out  city_index, step_distance, total_distance,           valid && ready
//                tour_end, overflow
//
// a city request is stored when taken, or dropped once the store is full;
// ready is high only between tours
// each move reads the stored cities through the read port of the coordinate
// memory, then passes three stages of distance pipeline, the bit-serial square
// root and the output register; the closing return reads city 0 only
// rst_ni clears control state at once, no clearing pass; a stalled output
// holds the tour at its emit step until the move request is taken
module nearest_neighbour_tour
  import nnt_pkg::*;
#(
  parameter int unsigned MAX_CITIES = MAX_CITIES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  nnt_city_if.sink   city_i,
  nnt_move_if.source move_o
);

  localparam int unsigned IDX_W = $clog2(MAX_CITIES);
  localparam int unsigned CNT_W = $clog2(MAX_CITIES + 1);
  localparam int unsigned PT_W  = 2 * COORD_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_ROOT  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // set and tour control
  logic [CNT_W-1:0]      count_q;
  logic                  drop_q;
  logic [IDX_W-1:0]      moves_q;
  logic                  ret_q;
  logic [IDX_W-1:0]      scan_j_q;
  logic [MAX_CITIES-1:0] vis_q;
  logic [TOTAL_W-1:0]    total_q;
  logic [COORD_W-1:0]    cur_x_q, cur_y_q;

  // best candidate of the scan
  logic                  found_q;
  logic [SQ_W-1:0]       best_d_q;
  logic [IDX_W-1:0]      best_j_q;
  logic [COORD_W-1:0]    best_x_q, best_y_q;

  // distance pipeline
  logic                  rd_v_q, rd_cand_q;
  logic [IDX_W-1:0]      rd_j_q;
  logic                  a_v_q, a_cand_q;
  logic [IDX_W-1:0]      a_j_q;
  logic [COORD_W-1:0]    a_dx_q, a_dy_q, a_x_q, a_y_q;
  logic                  b_v_q, b_cand_q;
  logic [IDX_W-1:0]      b_j_q;
  logic [PT_W-1:0]       b_sqx_q, b_sqy_q;
  logic [COORD_W-1:0]    b_x_q, b_y_q;

  // output register
  logic                  out_v_q;
  logic [CITY_W-1:0]     out_city_q;
  logic [STEP_W-1:0]     out_step_q;
  logic [TOTAL_W-1:0]    out_total_q;
  logic                  out_end_q, out_ovf_q;

  logic                  accept_in, has_room, last_in;
  logic [CNT_W-1:0]      count_d, cnt_m1;
  logic [IDX_W-1:0]      scan_end, moves_nx;
  logic                  cand, pipe_empty, better, slot_free, emit;
  logic [PT_W-1:0]       rdata;
  logic [COORD_W-1:0]    rx, ry;
  logic [SQ_W-1:0]       dsum;
  logic                  sq_start, sq_done;
  logic [STEP_W-1:0]     sq_root;
  logic [TOTAL_W:0]      sum_w;
  logic [TOTAL_W-1:0]    total_nx;

  // load side
  assign city_i.ready = (state_q == ST_IDLE);
  assign accept_in    = city_i.valid && city_i.ready;
  assign last_in      = city_i.last_city;
  assign has_room     = (count_q < CNT_W'(MAX_CITIES));
  assign count_d      = has_room ? (count_q + CNT_W'(1)) : count_q;

  // scan bounds and candidate selection
  assign cnt_m1   = count_q - CNT_W'(1);
  assign scan_end = ret_q ? '0 : cnt_m1[IDX_W-1:0];
  assign cand     = ret_q ? (scan_j_q == '0) : !vis_q[scan_j_q];
  assign moves_nx = moves_q + IDX_W'(1);

  // coordinate memory, {x, y} per city
  nnt_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_CITIES)
  ) u_nnt_ram (
    .clk_i   (clk_i),
    .we_i    (accept_in && has_room),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i ({city_i.coord_x, city_i.coord_y}),
    .raddr_i (scan_j_q),
    .rdata_o (rdata)
  );

  assign rx = rdata[PT_W-1:COORD_W];
  assign ry = rdata[COORD_W-1:0];

  // final stage: sum and compare, lowest index wins a tie
  assign dsum       = {1'b0, b_sqx_q} + {1'b0, b_sqy_q};
  assign better     = b_v_q && b_cand_q && (!found_q || (dsum < best_d_q));
  assign pipe_empty = !rd_v_q && !a_v_q && !b_v_q;

  // square root of the winning distance
  assign sq_start = (state_q == ST_DRAIN) && pipe_empty;

  nnt_isqrt u_nnt_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (best_d_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // saturating running total
  assign sum_w     = {1'b0, total_q} + (TOTAL_W + 1)'(sq_root);
  assign total_nx  = sum_w[TOTAL_W] ? TOTAL_MAX : sum_w[TOTAL_W-1:0];
  assign slot_free = !out_v_q || move_o.ready;
  assign emit      = (state_q == ST_EMIT) && slot_free;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept_in && last_in) state_d = ST_SCAN;
      ST_SCAN:  if (scan_j_q == scan_end) state_d = ST_DRAIN;
      ST_DRAIN: if (pipe_empty) state_d = ST_ROOT;
      ST_ROOT:  if (sq_done) state_d = ST_EMIT;
      ST_EMIT:  if (slot_free) state_d = ret_q ? ST_IDLE : ST_SCAN;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      drop_q   <= 1'b0;
      moves_q  <= '0;
      ret_q    <= 1'b0;
      scan_j_q <= '0;
      vis_q    <= '0;
      total_q  <= '0;
      found_q  <= 1'b0;
      rd_v_q   <= 1'b0;
      a_v_q    <= 1'b0;
      b_v_q    <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= (state_q == ST_SCAN);
      a_v_q   <= rd_v_q;
      b_v_q   <= a_v_q;
      if (better) begin
        found_q <= 1'b1;
      end
      // output register: loaded on emit, cleared once taken
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (move_o.ready) begin
        out_v_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept_in) begin
            count_q <= count_d;
            if (!has_room) begin
              drop_q <= 1'b1;
            end
            if (last_in) begin
              ret_q    <= (count_d == CNT_W'(1));
              moves_q  <= '0;
              scan_j_q <= '0;
              found_q  <= 1'b0;
              vis_q    <= MAX_CITIES'(1);
              total_q  <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (scan_j_q != scan_end) begin
            scan_j_q <= scan_j_q + IDX_W'(1);
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            if (ret_q) begin
              count_q <= '0;
              drop_q  <= 1'b0;
              total_q <= '0;
              vis_q   <= '0;
              ret_q   <= 1'b0;
            end else begin
              total_q         <= total_nx;
              vis_q[best_j_q] <= 1'b1;
              moves_q         <= moves_nx;
              ret_q           <= (CNT_W'(moves_nx) == cnt_m1);
              scan_j_q        <= '0;
              found_q         <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    // first stage: coordinate differences
    rd_j_q    <= scan_j_q;
    rd_cand_q <= cand;
    a_j_q     <= rd_j_q;
    a_cand_q  <= rd_cand_q;
    a_dx_q    <= (rx > cur_x_q) ? (rx - cur_x_q) : (cur_x_q - rx);
    a_dy_q    <= (ry > cur_y_q) ? (ry - cur_y_q) : (cur_y_q - ry);
    a_x_q     <= rx;
    a_y_q     <= ry;
    // second stage: squares
    b_j_q     <= a_j_q;
    b_cand_q  <= a_cand_q;
    b_sqx_q   <= PT_W'(a_dx_q) * PT_W'(a_dx_q);
    b_sqy_q   <= PT_W'(a_dy_q) * PT_W'(a_dy_q);
    b_x_q     <= a_x_q;
    b_y_q     <= a_y_q;
    // best so far
    if (better) begin
      best_d_q <= dsum;
      best_j_q <= b_j_q;
      best_x_q <= b_x_q;
      best_y_q <= b_y_q;
    end
    // city 0 starts as the current city
    if (accept_in && (count_q == '0)) begin
      cur_x_q <= city_i.coord_x;
      cur_y_q <= city_i.coord_y;
    end
    // result into the output register
    if (emit) begin
      cur_x_q     <= best_x_q;
      cur_y_q     <= best_y_q;
      out_city_q  <= CITY_W'(best_j_q);
      out_step_q  <= sq_root;
      out_total_q <= total_nx;
      out_end_q   <= ret_q;
      out_ovf_q   <= drop_q;
    end
  end

  assign move_o.valid          = out_v_q;
  assign move_o.city_index     = out_city_q;
  assign move_o.step_distance  = out_step_q;
  assign move_o.total_distance = out_total_q;
  assign move_o.tour_end       = out_end_q;
  assign move_o.overflow       = out_ovf_q;

endmodule

### src/nnt_ram.sv
module nnt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/nnt_isqrt.sv
module nnt_isqrt
  import nnt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQ_W-1:0]   value_i,
  output logic              done_o,
  output logic [STEP_W-1:0] root_o
);

  localparam int unsigned VAL_W = 2 * STEP_W;
  localparam int unsigned REM_W = STEP_W + 3;
  localparam int unsigned IT_W  = $clog2(STEP_W + 1);

  logic [VAL_W-1:0]  val_q;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [STEP_W-1:0] root_q, root_d;
  logic [IT_W-1:0]   cnt_q;
  logic              busy_q, done_q;

  logic [REM_W-1:0]  rem_sh, trial;
  logic              ge;

  // one result bit per cycle, restoring digit recurrence
  always_comb begin
    rem_sh = {rem_q[REM_W-3:0], val_q[VAL_W-1 -: 2]};
    trial  = REM_W'({root_q, 2'b01});
    ge     = (rem_sh >= trial);
    rem_d  = ge ? (rem_sh - trial) : rem_sh;
    root_d = {root_q[STEP_W-2:0], ge};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= IT_W'(STEP_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - IT_W'(1);
        if (cnt_q == IT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= VAL_W'(value_i);
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q  <= {val_q[VAL_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### src/nnt_checker.sv
`include "assert_macros.svh"

module nnt_checker
  import nnt_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [CITY_W-1:0]  city_index_i,
  input logic [STEP_W-1:0]  step_distance_i,
  input logic [TOTAL_W-1:0] total_distance_i,
  input logic               tour_end_i
);

  // no move request during reset
  `NNT_ASSERT_RST(a_rst_quiet, !rst_ni |-> !out_valid_i, "move request during reset")

  // a stalled move request stays up
  `NNT_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "move request dropped")

  // the closing move returns to city 0
  `NNT_ASSERT(a_end_home, out_valid_i && tour_end_i |-> city_index_i == '0, "return not to city 0")

  // a running total never falls below the move it includes
  `NNT_ASSERT(a_total_ge, out_valid_i |-> total_distance_i >= TOTAL_W'(step_distance_i), "total below step")

  // no city loading while a tour is still under way
  `NNT_ASSERT(a_no_load, out_valid_i && !tour_end_i |-> !in_ready_i, "load during tour")

endmodule

bind nearest_neighbour_tour nnt_checker u_nnt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (city_i.ready),
  .out_valid_i      (move_o.valid),
  .out_ready_i      (move_o.ready),
  .city_index_i     (move_o.city_index),
  .step_distance_i  (move_o.step_distance),
  .total_distance_i (move_o.total_distance),
  .tour_end_i       (move_o.tour_end)
);
